// ----- design/rotr_pkg.sv -----
package rotr_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int COLOR_W     = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   // request functions
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 8'd128;

   typedef struct packed {
      logic               func;
      logic [COLOR_W-1:0] red_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic               pixel_valid;
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
      logic               last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

   // status of one drain beat, carried to the response stage
   typedef struct packed {
      logic pixel_valid;
      logic last_pixel;
   } meta_type;

endpackage

// ----- design/rotr_store.sv -----
module rotr_store #(
   parameter int ADDR_W = 14
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   addr,
   input  rotr_pkg::pixel_type wdata,
   output rotr_pkg::pixel_type rdata
);
   import rotr_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   pixel_type mem [DEPTH];
   pixel_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/rotr_ctrl.sv -----
module rotr_ctrl #(
   parameter int MAX_DIM = 128,
   parameter int DIM_W   = 7,
   parameter int ADDR_W  = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_fire,
   input  logic [rotr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rotr_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 req_fire,
   input  rotr_pkg::req_type                    req_data,
   output logic                                 mem_wr_en,
   output logic                                 mem_rd_en,
   output logic [ADDR_W-1:0]                    mem_addr,
   output rotr_pkg::pixel_type                  mem_wdata,
   output logic                                 rsp_push,
   output rotr_pkg::meta_type                   rsp_meta
);
   import rotr_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIM + 1);

   function automatic logic [CNT_W-1:0] eff_dim(input logic [CSR_DATA_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = CNT_W'(MAX_DIM);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   logic [CNT_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] load_row_ff, load_row_in;
   logic [DIM_W-1:0] load_col_ff, load_col_in;
   logic [DIM_W-1:0] emit_row_ff, emit_row_in;
   logic [DIM_W-1:0] emit_col_ff, emit_col_in;
   logic             ready_ff, ready_in;

   logic [DIM_W-1:0] lr, lc;
   logic [CNT_W-1:0] lr_inc, lc_inc, er_inc, ec_inc, src_row;
   logic             drain_ok;
   logic             csr_hit;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      ready_in    = ready_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_addr    = '0;
      mem_wdata   = {req_data.red_in, req_data.green_in, req_data.blue_in};
      rsp_push    = 1'b0;
      rsp_meta    = '0;

      // wrap a stale load position back to the origin
      if (CNT_W'(load_row_ff) >= height_ff || CNT_W'(load_col_ff) >= width_ff) begin
         lr = '0;
         lc = '0;
      end else begin
         lr = load_row_ff;
         lc = load_col_ff;
      end
      lr_inc   = CNT_W'(lr) + CNT_W'(1);
      lc_inc   = CNT_W'(lc) + CNT_W'(1);
      er_inc   = CNT_W'(emit_row_ff) + CNT_W'(1);
      ec_inc   = CNT_W'(emit_col_ff) + CNT_W'(1);
      src_row  = height_ff - CNT_W'(1) - CNT_W'(emit_col_ff);
      drain_ok = ready_ff && (CNT_W'(emit_row_ff) < width_ff)
                 && (CNT_W'(emit_col_ff) < height_ff);
      // writes to unused indexes are dropped
      csr_hit  = (csr_index == REG_FRAME_WIDTH) || (csr_index == REG_FRAME_HEIGHT);

      if (csr_fire) begin
         if (csr_hit) begin
            load_row_in = '0;
            load_col_in = '0;
            emit_row_in = '0;
            emit_col_in = '0;
            ready_in    = 1'b0;
         end
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_in  = eff_dim(csr_data);
            REG_FRAME_HEIGHT: height_in = eff_dim(csr_data);
            default: ;
         endcase
      end else if (req_fire) begin
         unique case (req_data.func)
            FUNC_LOAD: begin
               if (ready_ff) begin
                  ready_in    = 1'b0;
                  emit_row_in = '0;
                  emit_col_in = '0;
               end
               mem_wr_en = 1'b1;
               mem_addr  = {lr, lc};
               if (lc_inc >= width_ff) begin
                  load_col_in = '0;
                  if (lr_inc >= height_ff) begin
                     load_row_in = '0;
                     ready_in    = 1'b1;
                     emit_row_in = '0;
                     emit_col_in = '0;
                  end else begin
                     load_row_in = lr_inc[DIM_W-1:0];
                  end
               end else begin
                  load_row_in = lr;
                  load_col_in = lc_inc[DIM_W-1:0];
               end
            end
            FUNC_DRAIN: begin
               rsp_push = 1'b1;
               if (drain_ok) begin
                  mem_rd_en            = 1'b1;
                  mem_addr             = {src_row[DIM_W-1:0], emit_row_ff};
                  rsp_meta.pixel_valid = 1'b1;
                  if (ec_inc >= height_ff) begin
                     emit_col_in = '0;
                     if (er_inc >= width_ff) begin
                        emit_row_in         = '0;
                        rsp_meta.last_pixel = 1'b1;
                        ready_in            = 1'b0;
                     end else begin
                        emit_row_in = er_inc[DIM_W-1:0];
                     end
                  end else begin
                     emit_col_in = ec_inc[DIM_W-1:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= eff_dim(DIM_RESET);
         height_ff   <= eff_dim(DIM_RESET);
         load_row_ff <= '0;
         load_col_ff <= '0;
         emit_row_ff <= '0;
         emit_col_ff <= '0;
         ready_ff    <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         emit_row_ff <= emit_row_in;
         emit_col_ff <= emit_col_in;
         ready_ff    <= ready_in;
      end
   end

endmodule

// ----- design/image_rotate_right.sv -----
// Response: a drain beat's response is registered and presented in the cycle after its request is accepted.
// Throughput: one beat per cycle, load or drain; the single-port frame store takes one
//   access per beat. A held response stalls further requests until it is taken.
// Reset (synchronous): positions, frame-ready and the response valid flag clear; both
//   dimensions return to 128 (clamped to MAX_DIM). Frame store contents are not cleared.
module image_rotate_right #(
   parameter int MAX_DIM = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rotr_pkg::req_type                req_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rotr_pkg::rsp_type                rsp_data,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rotr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rotr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rotr_pkg::*;

   // Store is addressed {row, col}; each coordinate gets DIM_W bits.
   localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_W = 2 * DIM_W;

   logic              req_fire, csr_fire;
   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_addr;
   pixel_type         mem_wdata, mem_rdata;
   logic              rsp_push;
   meta_type          rsp_meta;

   // response stage: meta flags registered with the store read
   logic              rsp_valid_ff, rsp_valid_in;
   meta_type          meta_ff, meta_in;

   // Next beat accepted once the response slot is free or leaving.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   // Register writes only land while idle is a rule for the user (not enforced here); they are always taken.
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   rotr_ctrl #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W),
      .ADDR_W  (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_fire),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_fire  (req_fire),
      .req_data  (req_data),
      .mem_wr_en (mem_wr_en),
      .mem_rd_en (mem_rd_en),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .rsp_push  (rsp_push),
      .rsp_meta  (rsp_meta)
   );

   // A write and a later read never share a cycle, so the read always sees
   // the write of the previous beat; no bypass needed.
   rotr_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .wr_en (mem_wr_en),
      .rd_en (mem_rd_en),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      meta_in      = meta_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_push) begin
         rsp_valid_in = 1'b1;
         meta_in      = rsp_meta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
   end

   // Store read data holds while the response waits: no new read happens
   // until the slot frees.
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.pixel_valid  = meta_ff.pixel_valid;
   assign rsp_data.red_out      = meta_ff.pixel_valid ? mem_rdata.red   : '0;
   assign rsp_data.green_out    = meta_ff.pixel_valid ? mem_rdata.green : '0;
   assign rsp_data.blue_out     = meta_ff.pixel_valid ? mem_rdata.blue  : '0;
   assign rsp_data.last_pixel   = meta_ff.last_pixel;

endmodule

// ----- dv/image_rotate_right_test.sv -----
module image_rotate_right_test;
   import rotr_pkg::*;

   localparam int MAX_DIM     = 128;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   image_rotate_right #(.MAX_DIM(MAX_DIM)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow copy of the rotator: registers, positions and frame store
   // ---------------------------------------------------------------
   logic [CSR_DATA_W-1:0] width_reg  = DIM_RESET;
   logic [CSR_DATA_W-1:0] height_reg = DIM_RESET;
   int        load_row  = 0;
   int        load_col  = 0;
   int        emit_row  = 0;
   int        emit_col  = 0;
   bit        frame_ready = 1'b0;
   pixel_type frame_store [MAX_DIM*MAX_DIM];

   req_type beats_to_send [$];   // request beats not yet put on the port
   rsp_type rotated_due [$];     // one entry per accepted drain beat, oldest first
   int      beats_queued = 0;
   int      mismatches   = 0;

   // traffic shaping
   bit calm       = 1'b0;        // final stretch: no idle cycles on either side
   bit hold_start = 1'b0;
   bit rsp_hold   = 1'b0;        // long receiver hold-off
   int send_gap   = 0;
   int stall_left = 0;

   // 0 behaves as 1, anything above MAX_DIM saturates
   function automatic int dim_of(input logic [CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // Advance the shadow state by one accepted beat. Drains queue their pixel.
   function automatic void rotate_beat(input req_type item);
      int      w;
      int      h;
      int      src;
      rsp_type res;
      w = dim_of(width_reg);
      h = dim_of(height_reg);
      if (item.func == FUNC_LOAD) begin
         // a load on a finished frame throws it away and starts over
         if (frame_ready) begin
            frame_ready = 1'b0;
            emit_row    = 0;
            emit_col    = 0;
         end
         if (load_row >= h || load_col >= w) begin
            load_row = 0;
            load_col = 0;
         end
         frame_store[load_row*MAX_DIM + load_col] = {item.red_in, item.green_in, item.blue_in};
         if (load_col + 1 >= w) begin
            load_col = 0;
            if (load_row + 1 >= h) begin
               load_row    = 0;
               frame_ready = 1'b1;
               emit_row    = 0;
               emit_col    = 0;
            end else begin
               load_row++;
            end
         end else begin
            load_col++;
         end
      end else begin
         res = '0;
         if (frame_ready && emit_row < w && emit_col < h) begin
            // output (r, c) comes from input (h-1-c, r)
            src = (h - 1 - emit_col)*MAX_DIM + emit_row;
            res.pixel_valid = 1'b1;
            res.red_out     = frame_store[src].red;
            res.green_out   = frame_store[src].green;
            res.blue_out    = frame_store[src].blue;
            if (emit_col + 1 >= h) begin
               emit_col = 0;
               if (emit_row + 1 >= w) begin
                  emit_row        = 0;
                  res.last_pixel  = 1'b1;
                  frame_ready     = 1'b0;
               end else begin
                  emit_row++;
               end
            end else begin
               emit_col++;
            end
         end
         rotated_due.push_back(res);
      end
   endfunction

   function automatic void flag_bad(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: want v%0d rgb %02h%02h%02h last %0d, got v%0d rgb %02h%02h%02h last %0d",
                  what, want.pixel_valid, want.red_out, want.green_out, want.blue_out,
                  want.last_pixel, got.pixel_valid, got.red_out, got.green_out, got.blue_out,
                  got.last_pixel);
   endfunction

   // ---------------------------------------------------------------
   // Request driver: feeds beats_to_send, idles in short random bursts
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) rotate_beat(req_data);
         // free to change the port only when nothing is waiting on it
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (beats_to_send.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= beats_to_send.pop_front();
               if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor: checks every accepted beat against rotated_due
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rotated_due.size() == 0) begin
               flag_bad("unexpected response", '0, rsp_data);
            end else begin
               if (rsp_data.pixel_valid !== rotated_due[0].pixel_valid ||
                   rsp_data.red_out     !== rotated_due[0].red_out ||
                   rsp_data.green_out   !== rotated_due[0].green_out ||
                   rsp_data.blue_out    !== rotated_due[0].blue_out ||
                   rsp_data.last_pixel  !== rotated_due[0].last_pixel)
                  flag_bad("pixel mismatch", rotated_due[0], rsp_data);
               void'(rotated_due.pop_front());
            end
         end
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 4);
         end
      end
   end

   // Long hold-off on the response side so the block backs up into req_ready.
   initial begin : long_hold
      wait (hold_start);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      int n;
      n = 0;
      while (n < CYCLE_LIMIT) begin
         @(posedge clock);
         n++;
      end
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic void send(input req_type item);
      beats_to_send.push_back(item);
      beats_queued++;
   endfunction

   // colors are random on drains too; the block must ignore them
   function automatic req_type random_beat(input logic func);
      req_type item;
      item.func     = func;
      item.red_in   = 8'($urandom);
      item.green_in = 8'($urandom);
      item.blue_in  = 8'($urandom);
      return item;
   endfunction

   function automatic void push_loads(input int n);
      repeat (n) send(random_beat(FUNC_LOAD));
   endfunction

   function automatic void push_drains(input int n);
      repeat (n) send(random_beat(FUNC_DRAIN));
   endfunction

   function automatic void push_pixel(input pixel_type p);
      req_type item;
      item.func     = FUNC_LOAD;
      item.red_in   = p.red;
      item.green_in = p.green;
      item.blue_in  = p.blue;
      send(item);
   endfunction

   // block idle: nothing to send, nothing in flight, plus a trailing wait for a last load
   task automatic wait_quiet();
      while (beats_to_send.size() != 0 || req_valid || rotated_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // a write to the width or height register restarts the rotator
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH:  width_reg  = val;
         REG_FRAME_HEIGHT: height_reg = val;
         default: ;
      endcase
      load_row    = 0;
      load_col    = 0;
      emit_row    = 0;
      emit_col    = 0;
      frame_ready = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      logic [CSR_DATA_W-1:0] wv;
      logic [CSR_DATA_W-1:0] hv;
      logic [CSR_DATA_W-1:0] swap;
      int                    frame_pixels;
      int                    rounds;

      foreach (frame_store[i]) frame_store[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // drain straight out of reset: no frame yet
      push_drains(1);
      wait_quiet();

      // zero width acts as one column; 1x2 frame with all-ones and all-zeros pixels
      write_reg(REG_FRAME_WIDTH, 8'd0);
      write_reg(REG_FRAME_HEIGHT, 8'd2);
      push_pixel('1);
      push_pixel('0);
      push_drains(3);        // two pixels, last flagged, then frame is gone
      wait_quiet();

      write_reg(REG_FRAME_WIDTH, 8'd2);
      write_reg(REG_FRAME_HEIGHT, 8'd1);
      push_loads(1);
      push_drains(1);        // half-loaded frame: nothing to give
      push_loads(1);
      push_drains(1);        // first of two, then cut short by a load
      push_loads(2);
      push_drains(3);        // fresh frame in full, one drain past the end
      push_loads(2);
      wait_quiet();
      write_reg(REG_FRAME_HEIGHT, 8'd1);   // restart drops the ready frame
      push_drains(1);
      wait_quiet();

      // --- back-pressure: receiver stops while a 4x4 frame is loaded and drained ---
      write_reg(REG_FRAME_WIDTH, 8'd4);
      write_reg(REG_FRAME_HEIGHT, 8'd4);
      hold_start <= 1'b1;
      push_loads(16);
      push_drains(20);

      // --- random phases ---
      for (int phase = 0; beats_queued < 1040; phase++) begin
         if (phase == 0) begin
            wv = 8'd255;           // saturates to a full-width row
            hv = 8'd0;
         end else if (phase == 1) begin
            wv = 8'd0;
            hv = 8'd255;
         end else if ($urandom_range(0, 15) == 0) begin
            // one big dimension, the other kept at one so the frame stays short
            wv = 8'($urandom_range(MAX_DIM, 255));
            hv = 8'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) begin
               swap = wv;
               wv   = hv;
               hv   = swap;
            end
         end else begin
            wv = 8'($urandom_range(1, 6));
            hv = 8'($urandom_range(1, 6));
         end
         if (beats_queued > 870) calm <= 1'b1;
         wait_quiet();
         if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_FRAME_WIDTH, wv);
            write_reg(REG_FRAME_HEIGHT, hv);
         end else begin
            write_reg(REG_FRAME_HEIGHT, hv);
            write_reg(REG_FRAME_WIDTH, wv);
         end
         frame_pixels = dim_of(wv) * dim_of(hv);
         rounds = (frame_pixels > 64) ? 1 : $urandom_range(1, 3);
         repeat (rounds) begin
            case ($urandom_range(0, 9))
               7: begin
                  // partial drain, the next load cuts in
                  push_loads(frame_pixels);
                  push_drains($urandom_range(0, frame_pixels - 1));
               end
               8: begin
                  // partial load, drains usually find nothing
                  push_loads($urandom_range(1, frame_pixels));
                  push_drains($urandom_range(1, 2));
               end
               9: repeat ($urandom_range(1, 8)) send(random_beat(1'($urandom)));
               default: begin
                  push_loads(frame_pixels);
                  push_drains(frame_pixels + $urandom_range(0, 2));
               end
            endcase
         end
      end

      wait_quiet();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/rotr_pkg.sv
design/rotr_store.sv
design/rotr_ctrl.sv
design/image_rotate_right.sv
dv/image_rotate_right_test.sv
